FILE: hw/rtl/npct_pkg.sv
// Shared types and constants for the nearest palette color table.
// No dependencies; imported by the controller, the datapath and the top level.
package npct_pkg;

    localparam int ACT_W     = 2;
    localparam int TAG_W     = 8;
    localparam int COMP_IN_W = 16;
    localparam int COUNT_W   = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2
    } act_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // register the incoming transaction's tag and colors
        logic clear;      // reset result flags and the best distance
        logic add_wr;     // write the captured entry at the command address
        logic scan_rd;    // read the table at the command address
        logic find_mode;  // scanned data feeds the distance pipeline
        logic load_out;   // copy the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic found;      // remove located its tag
    } dp_status_t;

endpackage

FILE: hw/rtl/npct_datapath.sv
// Datapath of the palette table: entry memory, input capture with clamping,
// tag match and gap closing for remove, and the distance pipeline for find.
// Depends on npct_pkg; driven by npct_ctrl.
module npct_datapath #(
    parameter int TABLE_DEPTH     = 64,
    parameter int COLOR_FRAC_BITS = 8,
    parameter int ADDR_W          = $clog2(TABLE_DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  npct_pkg::dp_cmd_t                   cmd,
    input  logic [ADDR_W-1:0]                   addr,
    input  logic [npct_pkg::TAG_W-1:0]          tag,
    input  logic signed [npct_pkg::COMP_IN_W-1:0] red_in,
    input  logic signed [npct_pkg::COMP_IN_W-1:0] green_in,
    input  logic signed [npct_pkg::COMP_IN_W-1:0] blue_in,
    output npct_pkg::dp_status_t                status,
    output logic                                success,
    output logic [npct_pkg::TAG_W-1:0]          result_tag
);
    import npct_pkg::*;

    localparam int CW    = COLOR_FRAC_BITS + 1;
    localparam int SQ_W  = 2 * COLOR_FRAC_BITS + 1;
    localparam int DW    = SQ_W + 1;
    localparam int ENT_W = TAG_W + 3 * CW;
    localparam logic [COMP_IN_W-1:0] COLOR_ONE = COMP_IN_W'(1) << COLOR_FRAC_BITS;
    localparam logic [DW-1:0] DIST_BOUND = DW'(3) << (2 * COLOR_FRAC_BITS);

    function automatic logic [CW-1:0] clamp_comp(input logic [COMP_IN_W-1:0] v);
        logic [CW-1:0] c;
        if (v[COMP_IN_W-1]) begin
            c = '0;
        end else if (v > COLOR_ONE) begin
            c = COLOR_ONE[CW-1:0];
        end else begin
            c = v[CW-1:0];
        end
        return c;
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [SQ_W-1:0] d;
        d = (a > b) ? SQ_W'(a - b) : SQ_W'(b - a);
        return d * d;
    endfunction

    logic [ENT_W-1:0] mem [TABLE_DEPTH];

    logic [TAG_W-1:0]  tag_in_reg;
    logic [CW-1:0]     r_in_reg, g_in_reg, b_in_reg;
    logic [ENT_W-1:0]  q_reg;
    logic [ADDR_W-1:0] q_addr_reg;
    logic              q_valid_reg;
    logic              found_reg;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic [TAG_W-1:0]  sq_tag_reg;
    logic              sq_valid_reg;
    logic [DW-1:0]     best_reg;
    logic              exact_reg;
    logic              ok_reg;
    logic [TAG_W-1:0]  res_tag_reg;
    logic              success_reg;
    logic [TAG_W-1:0]  result_tag_reg;

    logic [TAG_W-1:0]  q_tag;
    logic [CW-1:0]     q_r, q_g, q_b;
    logic              remove_live;
    logic              shift_wr;
    logic              tag_hit;
    logic [DW-1:0]     dist_sum;
    logic              take_best;

    assign q_tag = q_reg[ENT_W-1 -: TAG_W];
    assign q_r   = q_reg[3*CW-1 -: CW];
    assign q_g   = q_reg[2*CW-1 -: CW];
    assign q_b   = q_reg[CW-1 -: CW];

    assign remove_live = q_valid_reg && !cmd.find_mode;
    // Once the tag is found, every later entry moves down by one place.
    assign shift_wr    = remove_live && found_reg;
    assign tag_hit     = remove_live && !found_reg && (q_tag == tag_in_reg);

    assign dist_sum  = DW'(sq_r_reg) + DW'(sq_g_reg) + DW'(sq_b_reg);
    assign take_best = sq_valid_reg && !exact_reg && (dist_sum <= best_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_in_reg <= tag;
            r_in_reg   <= clamp_comp(red_in);
            g_in_reg   <= clamp_comp(green_in);
            b_in_reg   <= clamp_comp(blue_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
        begin
            mem[addr] <= {tag_in_reg, r_in_reg, g_in_reg, b_in_reg};
        end
        else if (shift_wr)
        begin
            mem[q_addr_reg - ADDR_W'(1)] <= q_reg;
        end
        if (cmd.scan_rd)
        begin
            q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        q_addr_reg <= addr;
        sq_r_reg   <= sq_diff(r_in_reg, q_r);
        sq_g_reg   <= sq_diff(g_in_reg, q_g);
        sq_b_reg   <= sq_diff(b_in_reg, q_b);
        sq_tag_reg <= q_tag;
        if (take_best)
        begin
            best_reg <= dist_sum;
        end
        else if (cmd.clear)
        begin
            best_reg <= DIST_BOUND;
        end
        if (cmd.load_out)
        begin
            success_reg    <= ok_reg;
            result_tag_reg <= res_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg  <= 1'b0;
            sq_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            exact_reg    <= 1'b0;
            ok_reg       <= 1'b0;
            res_tag_reg  <= '0;
        end
        else
        begin
            q_valid_reg  <= cmd.scan_rd;
            sq_valid_reg <= q_valid_reg && cmd.find_mode;
            if (cmd.clear)
            begin
                found_reg   <= 1'b0;
                exact_reg   <= 1'b0;
                ok_reg      <= 1'b0;
                res_tag_reg <= '0;
            end
            else if (cmd.add_wr)
            begin
                ok_reg      <= 1'b1;
                res_tag_reg <= tag_in_reg;
            end
            else if (tag_hit)
            begin
                found_reg <= 1'b1;
                ok_reg    <= 1'b1;
            end
            else if (take_best)
            begin
                ok_reg      <= 1'b1;
                res_tag_reg <= sq_tag_reg;
                exact_reg   <= (dist_sum == '0);
            end
        end
    end

    assign status.found = found_reg;
    assign success      = success_reg;
    assign result_tag   = result_tag_reg;

endmodule

FILE: hw/rtl/npct_ctrl.sv
// Controller of the palette table: sequences add, remove and find, owns the
// entry count and the output valid. Depends on npct_pkg; drives npct_datapath.
module npct_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [npct_pkg::ACT_W-1:0]    action,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [npct_pkg::COUNT_W-1:0]  entry_count,
    output npct_pkg::dp_cmd_t             cmd,
    output logic [ADDR_W-1:0]             addr,
    input  npct_pkg::dp_status_t          status
);
    import npct_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    act_t               act_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   issue_reg;
    logic               drain_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    logic accept;
    logic out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = accept;
        cmd.clear     = accept;
        cmd.add_wr    = (state_reg == ST_ADD);
        cmd.scan_rd   = (state_reg == ST_SCAN);
        cmd.find_mode = (act_reg == ACT_FIND);
        cmd.load_out  = (state_reg == ST_FINISH) && out_free;
        if (state_reg == ST_ADD)
        begin
            addr = count_reg[ADDR_W-1:0];
        end
        else
        begin
            addr = issue_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            act_reg         <= ACT_ADD;
            count_reg       <= '0;
            issue_reg       <= '0;
            drain_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            // In ST_FINISH a free output register is reloaded below instead.
            if (out_valid_reg && !out_stall && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg   <= act_t'(action);
                        issue_reg <= '0;
                        drain_reg <= 1'b0;
                        case (action)
                            ACT_ADD:
                            begin
                                if (count_reg < CNT_W'(TABLE_DEPTH))
                                begin
                                    state_reg <= ST_ADD;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            ACT_REMOVE, ACT_FIND:
                            begin
                                if (count_reg != '0)
                                begin
                                    state_reg <= ST_SCAN;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_ADD:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_FINISH;
                end
                ST_SCAN:
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                    if (issue_reg + CNT_W'(1) == count_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    // ST_DRAIN waits for drain_reg, so the last read can pass the tag match and the
                    // distance compare.
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        state_reg <= ST_FINISH;
                        if (act_reg == ACT_REMOVE && status.found)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        entry_count_reg <= COUNT_W'(count_reg);
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_count = entry_count_reg;

endmodule

FILE: hw/rtl/nearest_palette_color_table_unit.sv
// Top level of the nearest palette color table.
// Depends on npct_pkg, npct_ctrl and npct_datapath.
//
// Channel   Signals                                   Direction
// input     in_valid, in_stall, action, tag,          transaction into the table
//           red_in, green_in, blue_in
// output    out_valid, out_stall, success,            one result per transaction
//           result_tag, entry_count
//
// Add writes the entry in ST_ADD before ST_FINISH. Remove and find read the table
// one entry per cycle through a single read port, then pass ST_DRAIN; on an empty
// table remove and find, like an unused action, go straight to ST_FINISH.
// Reset clears the entry count; table contents are undefined until written.
// A new transaction is accepted while a result waits in the output register;
// its own result is held back until that register is free.
module nearest_palette_color_table_unit #(
    parameter int TABLE_DEPTH     = 64,
    parameter int COLOR_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [npct_pkg::ACT_W-1:0]            action,
    input  logic [npct_pkg::TAG_W-1:0]            tag,
    input  logic signed [npct_pkg::COMP_IN_W-1:0] red_in,
    input  logic signed [npct_pkg::COMP_IN_W-1:0] green_in,
    input  logic signed [npct_pkg::COMP_IN_W-1:0] blue_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  success,
    output logic [npct_pkg::TAG_W-1:0]            result_tag,
    output logic [npct_pkg::COUNT_W-1:0]          entry_count
);
    import npct_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [ADDR_W-1:0] addr;

    npct_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .entry_count (entry_count),
        .cmd         (cmd),
        .addr        (addr),
        .status      (status)
    );

    npct_datapath #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .COLOR_FRAC_BITS (COLOR_FRAC_BITS),
        .ADDR_W          (ADDR_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .addr       (addr),
        .tag        (tag),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .status     (status),
        .success    (success),
        .result_tag (result_tag)
    );

endmodule

FILE: tb/tb_nearest_palette_color_table_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_palette_color_table_unit: directed and random
// transactions checked against a shadow palette table. Depends on npct_pkg and the unit.
module tb_nearest_palette_color_table_unit;
    import npct_pkg::*;

    localparam int TABLE_DEPTH     = 64;
    localparam int COLOR_FRAC_BITS = 8;
    localparam int COLOR_ONE       = 1 << COLOR_FRAC_BITS;
    localparam int COMP_W          = COLOR_FRAC_BITS + 1;
    localparam int IDLE_PERCENT    = 20;
    localparam int DRAIN_CYCLES    = 100;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [TAG_W-1:0]  tag;
    } swatch_t;

    typedef struct packed {
        logic               success;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } lookup_result_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic [ACT_W-1:0]            action    = ACT_ADD;
    logic [TAG_W-1:0]            tag       = '0;
    logic signed [COMP_IN_W-1:0] red_in    = '0;
    logic signed [COMP_IN_W-1:0] green_in  = '0;
    logic signed [COMP_IN_W-1:0] blue_in   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        success;
    logic [TAG_W-1:0]            result_tag;
    logic [COUNT_W-1:0]          entry_count;

    bit             idle_enable = 1'b1;
    int             error_count = 0;
    swatch_t        palette_shadow [TABLE_DEPTH];
    int             palette_used = 0;
    lookup_result_t pending_results [$];

    nearest_palette_color_table_unit #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .COLOR_FRAC_BITS (COLOR_FRAC_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .tag         (tag),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .success     (success),
        .result_tag  (result_tag),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [COMP_W-1:0] clamp_component(logic signed [COMP_IN_W-1:0] raw);
        int value;
        value = raw;
        if (value < 0)
            value = 0;
        if (value > COLOR_ONE)
            value = COLOR_ONE;
        return COMP_W'(value);
    endfunction

    // Applies one transaction to the shadow table and returns the result it must produce.
    function automatic lookup_result_t apply_palette_action(
        logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag_val,
        logic signed [COMP_IN_W-1:0] red_raw, logic signed [COMP_IN_W-1:0] green_raw,
        logic signed [COMP_IN_W-1:0] blue_raw);
        lookup_result_t res;
        swatch_t        probe;
        int             best;
        int             sq_dist;
        int             hit;
        int             dr;
        int             dg;
        int             db;
        res         = '0;
        probe.red   = clamp_component(red_raw);
        probe.green = clamp_component(green_raw);
        probe.blue  = clamp_component(blue_raw);
        probe.tag   = tag_val;
        case (act)
            ACT_ADD:
            begin
                if (palette_used < TABLE_DEPTH)
                begin
                    palette_shadow[palette_used] = probe;
                    palette_used++;
                    res.success = 1'b1;
                    res.tag     = tag_val;
                end
            end
            ACT_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < palette_used; i++)
                    if (hit < 0 && palette_shadow[i].tag == tag_val)
                        hit = i;
                if (hit >= 0)
                begin
                    for (int j = hit; j + 1 < palette_used; j++)
                        palette_shadow[j] = palette_shadow[j + 1];
                    palette_used--;
                    res.success = 1'b1;
                end
            end
            ACT_FIND:
            begin
                // The bound equals the largest possible distance, so the first entry wins
                // at worst; later entries win ties, except that an exact match ends the scan.
                best = 3 << (2 * COLOR_FRAC_BITS);
                for (int i = 0; i < palette_used; i++)
                begin
                    dr      = int'(probe.red) - int'(palette_shadow[i].red);
                    dg      = int'(probe.green) - int'(palette_shadow[i].green);
                    db      = int'(probe.blue) - int'(palette_shadow[i].blue);
                    sq_dist = dr * dr + dg * dg + db * db;
                    if (sq_dist <= best)
                    begin
                        best        = sq_dist;
                        res.tag     = palette_shadow[i].tag;
                        res.success = 1'b1;
                        if (sq_dist == 0)
                            break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count = COUNT_W'(palette_used);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] tag_val,
                             input logic signed [COMP_IN_W-1:0] red_raw,
                             input logic signed [COMP_IN_W-1:0] green_raw,
                             input logic signed [COMP_IN_W-1:0] blue_raw);
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        tag      <= tag_val;
        red_in   <= red_raw;
        green_in <= green_raw;
        blue_in  <= blue_raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(
            apply_palette_action(act, tag_val, red_raw, green_raw, blue_raw));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [COMP_IN_W-1:0] random_component();
        case ($urandom_range(9))
            0:       return COMP_IN_W'($urandom);
            1:       return COMP_IN_W'(-int'($urandom_range(32768, 1)));
            2:       return COMP_IN_W'($urandom_range(32767, COLOR_ONE + 1));
            default: return COMP_IN_W'($urandom_range(COLOR_ONE));
        endcase
    endfunction

    function automatic int jitter();
        return $urandom_range(1) ? 0 : int'($urandom_range(4)) - 2;
    endfunction

    task automatic send_random_item(input int add_percent);
        int                          roll;
        logic [ACT_W-1:0]            act;
        logic [TAG_W-1:0]            tag_val;
        logic signed [COMP_IN_W-1:0] rgb [3];
        swatch_t                     seed_entry;
        roll = $urandom_range(99);
        if (roll < 2)
            act = ACT_UNUSED;
        else if (roll < add_percent)
            act = ACT_ADD;
        else if (roll < add_percent + (100 - add_percent) / 2)
            act = ACT_REMOVE;
        else
            act = ACT_FIND;
        // A small tag pool makes duplicate tags common.
        tag_val = $urandom_range(1) ? TAG_W'($urandom_range(7)) : TAG_W'($urandom);
        for (int k = 0; k < 3; k++)
            rgb[k] = random_component();
        if (palette_used > 0)
        begin
            seed_entry = palette_shadow[$urandom_range(palette_used - 1)];
            if (act == ACT_REMOVE && $urandom_range(3) != 0)
                tag_val = seed_entry.tag;
            // Colors on or next to a stored entry give exact matches and distance ties.
            if (act != ACT_REMOVE && $urandom_range(1))
            begin
                rgb[0] = COMP_IN_W'(int'(seed_entry.red) + jitter());
                rgb[1] = COMP_IN_W'(int'(seed_entry.green) + jitter());
                rgb[2] = COMP_IN_W'(int'(seed_entry.blue) + jitter());
            end
        end
        send_item(act, tag_val, rgb[0], rgb[1], rgb[2]);
    endtask

    task automatic test_empty_table();
        send_item(ACT_FIND, 8'h00, 0, 0, 0);
        send_item(ACT_REMOVE, 8'h00, 0, 0, 0);
        send_item(ACT_UNUSED, 8'hFF, -1, -1, -1);
    endtask

    task automatic test_clamping();
        send_item(ACT_ADD, 8'h00, -32768, 32767, 0);
        send_item(ACT_ADD, 8'hFF, 256, 257, -1);
        send_item(ACT_ADD, 8'hA5, 128, 127, 1);
        send_item(ACT_FIND, 8'h33, -5, 300, 0);
        send_item(ACT_FIND, 8'h00, 256, 32767, -32768);
        send_item(ACT_UNUSED, 8'h12, 1, 2, 3);
    endtask

    task automatic test_nearest_ties();
        send_item(ACT_ADD, 8'd10, 0, 0, 0);
        send_item(ACT_ADD, 8'd11, 2, 0, 0);
        send_item(ACT_FIND, 8'd0, 1, 0, 0);
        send_item(ACT_ADD, 8'd12, 0, 0, 0);
        send_item(ACT_FIND, 8'd0, 0, 0, 0);
        send_item(ACT_FIND, 8'd0, 1, 0, 0);
    endtask

    task automatic test_remove_cases();
        send_item(ACT_ADD, 8'd20, 64, 64, 64);
        send_item(ACT_ADD, 8'd20, 200, 200, 200);
        send_item(ACT_REMOVE, 8'd20, 0, 0, 0);
        send_item(ACT_FIND, 8'd0, 64, 64, 64);
        send_item(ACT_REMOVE, 8'd99, 0, 0, 0);
        send_item(ACT_REMOVE, 8'd20, 0, 0, 0);
        send_item(ACT_REMOVE, 8'd20, 0, 0, 0);
    endtask

    task automatic test_full_table();
        while (palette_used < TABLE_DEPTH)
            send_item(ACT_ADD, TAG_W'($urandom), random_component(), random_component(),
                      random_component());
        send_item(ACT_ADD, 8'h77, 10, 10, 10);
        wait_for_results();
        send_item(ACT_FIND, 8'h00, random_component(), random_component(), random_component());
        // Removing the head shifts every remaining entry down by one.
        send_item(ACT_REMOVE, palette_shadow[0].tag, 0, 0, 0);
        send_item(ACT_REMOVE, palette_shadow[palette_used - 1].tag, 0, 0, 0);
        send_item(ACT_FIND, 8'h00, random_component(), random_component(), random_component());
    endtask

    task automatic test_random_mix();
        int add_percent;
        for (int burst = 0; burst < 21; burst++)
        begin
            idle_enable = !(burst >= 6 && burst < 10);
            add_percent = $urandom_range(60, 25);
            repeat (50)
                send_random_item(add_percent);
        end
        idle_enable = 1'b1;
    endtask

    always @(negedge clk)
        out_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else
            begin
                want = pending_results.pop_front();
                if (success !== want.success)
                    report_mismatch("success", success, want.success);
                if (result_tag !== want.tag)
                    report_mismatch("result_tag", result_tag, want.tag);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", entry_count, want.count);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_clamping();
        test_nearest_ties();
        test_remove_cases();
        test_full_table();
        test_random_mix();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_nearest_palette_color_table_unit: done, clean");
        else
            $display("tb_nearest_palette_color_table_unit: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_nearest_palette_color_table_unit: done, errors");
        $finish;
    end

endmodule
